FILE: src/pcids_pkg.sv
// Shared types, codes and helper functions for the PCI config device search core.
`default_nettype none
package pcids_pkg;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HDR  = 2'd1,
      PH_SUB  = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   localparam logic [1:0] ST_REQ      = 2'd0;
   localparam logic [1:0] ST_FOUND    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   localparam logic        KIND_START  = 1'b0;
   localparam logic [15:0] NO_LOCATION = 16'hFFFF;
   localparam logic [7:0]  OFS_HEADER  = 8'h0C;
   localparam logic [7:0]  OFS_BRIDGE  = 8'h18;
   localparam logic [7:0]  OFS_CLASS   = 8'h08;
   localparam logic [7:0]  OFS_ID      = 8'h00;
   localparam logic [7:0]  HDR_ABSENT  = 8'hFF;
   localparam logic [2:0]  HDR_BRIDGE  = 3'd1;
   localparam logic [16:0] POS_LIMIT   = 17'h0FFFF;

   typedef struct packed {
      logic        kind;
      logic [31:0] search_value;
      logic [15:0] occurrence;
      logic        by_class;
      logic        skip_prog_if;
      logic [31:0] read_data;
   } item_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] position;
      logic [7:0]  last_bus;
      logic [7:0]  header_byte;
      logic        multi_function;
      logic [15:0] remaining;
      logic [31:0] target;
      logic        class_mode;
      logic        short_class;
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] req_bus_dev_fn;
      logic [7:0]  req_offset;
      logic [15:0] result_bus_dev_fn;
   } result_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] offset;
   } read_req_type;

   function automatic read_req_type compare_read(input logic cls);
      read_req_type r;
      r.phase  = PH_DATA;
      r.offset = cls ? OFS_CLASS : OFS_ID;
      return r;
   endfunction

   // header type known: bridge bus read on bus 0, else the compare read
   function automatic read_req_type after_header(input logic [15:0] pos,
                                                 input logic [7:0] hb,
                                                 input logic cls);
      read_req_type r;
      if (hb[2:0] == HDR_BRIDGE && pos[15:8] == 8'd0) begin
         r.phase  = PH_SUB;
         r.offset = OFS_BRIDGE;
      end else begin
         r = compare_read(cls);
      end
      return r;
   endfunction

   function automatic read_req_type probe(input logic [15:0] pos,
                                          input logic [7:0] hb,
                                          input logic cls);
      read_req_type r;
      if (pos[2:0] == 3'd0) begin
         r.phase  = PH_HDR;
         r.offset = OFS_HEADER;
      end else begin
         r = after_header(pos, hb, cls);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/pcids_step.sv
// Search step logic: next state and result word for one input word.
`default_nettype none
module pcids_step
   import pcids_pkg::*;
(
   input  wire item_type   item,
   input  wire state_type  cur,
   output state_type       nxt,
   output result_type      res
);

   logic [7:0]   hdr_byte;
   logic [16:0]  adv_sum;
   logic [15:0]  adv_pos;
   logic         adv_end;
   logic [31:0]  cmp_value;
   logic         match;
   logic         found;
   read_req_type hdr_req;
   read_req_type adv_req;
   read_req_type data_req;

   assign hdr_byte  = item.read_data[23:16];
   assign adv_sum   = {1'b0, cur.position} +
                      ((cur.phase == PH_DATA && cur.multi_function) ? 17'd1 : 17'd8);
   assign adv_pos   = adv_sum[15:0];
   assign adv_end   = (adv_sum >= POS_LIMIT) || (adv_sum[15:8] > cur.last_bus);
   assign cmp_value = !cur.class_mode ? item.read_data :
                      cur.short_class ? {16'd0, item.read_data[31:16]} :
                                        {8'd0, item.read_data[31:8]};
   assign match     = (cmp_value == cur.target);
   assign found     = match && (cur.remaining == 16'd0);
   assign hdr_req   = after_header(cur.position, hdr_byte, cur.class_mode);
   assign adv_req   = probe(adv_pos, cur.header_byte, cur.class_mode);
   assign data_req  = compare_read(cur.class_mode);

   // next state
   always_comb begin
      nxt = cur;
      if (item.kind == KIND_START) begin
         nxt.target      = item.search_value;
         nxt.remaining   = item.occurrence;
         nxt.class_mode  = item.by_class;
         nxt.short_class = item.skip_prog_if;
         nxt.position    = 16'd0;
         nxt.last_bus    = 8'd0;
         nxt.phase       = PH_HDR;
      end else begin
         unique case (cur.phase)
            PH_HDR: begin
               if (hdr_byte == HDR_ABSENT) begin
                  if (adv_end) begin
                     nxt.phase = PH_IDLE;
                  end else begin
                     nxt.position = adv_pos;
                     nxt.phase    = adv_req.phase;
                  end
               end else begin
                  nxt.header_byte    = hdr_byte;
                  nxt.multi_function = hdr_byte[7];
                  nxt.phase          = hdr_req.phase;
               end
            end
            PH_SUB: begin
               if (hdr_byte > cur.last_bus) begin
                  nxt.last_bus = hdr_byte;
               end
               nxt.phase = data_req.phase;
            end
            PH_DATA: begin
               if (found) begin
                  nxt.phase = PH_IDLE;
               end else begin
                  if (match) begin
                     nxt.remaining = cur.remaining - 16'd1;
                  end
                  if (adv_end) begin
                     nxt.phase = PH_IDLE;
                  end else begin
                     nxt.position = adv_pos;
                     nxt.phase    = adv_req.phase;
                  end
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

   // result word
   always_comb begin
      res.status            = ST_IGNORED;
      res.req_bus_dev_fn    = 16'd0;
      res.req_offset        = 8'd0;
      res.result_bus_dev_fn = NO_LOCATION;
      if (item.kind == KIND_START) begin
         res.status     = ST_REQ;
         res.req_offset = OFS_HEADER;
      end else begin
         unique case (cur.phase)
            PH_HDR: begin
               if (hdr_byte == HDR_ABSENT) begin
                  if (adv_end) begin
                     res.status = ST_NOTFOUND;
                  end else begin
                     res.status         = ST_REQ;
                     res.req_bus_dev_fn = adv_pos;
                     res.req_offset     = adv_req.offset;
                  end
               end else begin
                  res.status         = ST_REQ;
                  res.req_bus_dev_fn = cur.position;
                  res.req_offset     = hdr_req.offset;
               end
            end
            PH_SUB: begin
               res.status         = ST_REQ;
               res.req_bus_dev_fn = cur.position;
               res.req_offset     = data_req.offset;
            end
            PH_DATA: begin
               if (found) begin
                  res.status            = ST_FOUND;
                  res.result_bus_dev_fn = cur.position;
               end else if (adv_end) begin
                  res.status = ST_NOTFOUND;
               end else begin
                  res.status         = ST_REQ;
                  res.req_bus_dev_fn = adv_pos;
                  res.req_offset     = adv_req.offset;
               end
            end
            default: begin
               res.status = ST_IGNORED;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: src/pci_config_device_search_core.sv
// Top level of the PCI config device search core: input register, step logic, result register.
`default_nettype none
// One word per clock in sustained operation while rsp_ready does not stall the
// result register: an accepted word sits in the input register, the step logic
// decides it against the search state and the answer lands in the result
// register, so every input word yields exactly one result word.
// A start word (kind 0) aborts any search and answers with the first config
// read request; each returned dword (kind 1) answers with the next read request,
// found, or not found. A returned dword with no search running answers
// "ignored" and changes nothing.
module pci_config_device_search_core
   import pcids_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_kind,
   input  wire  [31:0] req_search_value,
   input  wire  [15:0] req_occurrence,
   input  wire         req_by_class,
   input  wire         req_skip_prog_if,
   input  wire  [31:0] req_read_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_req_bus_dev_fn,
   output logic [7:0]  rsp_req_offset,
   output logic [15:0] rsp_result_bus_dev_fn
);

   item_type   item_ff;
   logic       item_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type res_ff;
   result_type res_in;
   logic       rsp_valid_ff;
   logic       process;
   logic       accept;

   assign process   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || process;
   assign accept    = req_valid && req_ready;

   pcids_step u_step (
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (process) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind         <= req_kind;
         item_ff.search_value <= req_search_value;
         item_ff.occurrence   <= req_occurrence;
         item_ff.by_class     <= req_by_class;
         item_ff.skip_prog_if <= req_skip_prog_if;
         item_ff.read_data    <= req_read_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_IDLE;
         state_ff.position       <= 16'd0;
         state_ff.last_bus       <= 8'd0;
         state_ff.header_byte    <= 8'd0;
         state_ff.multi_function <= 1'b0;
         state_ff.remaining      <= 16'd0;
         state_ff.target         <= 32'd0;
         state_ff.class_mode     <= 1'b0;
         state_ff.short_class    <= 1'b0;
      end else if (process) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = res_ff.status;
   assign rsp_req_bus_dev_fn    = res_ff.req_bus_dev_fn;
   assign rsp_req_offset        = res_ff.req_offset;
   assign rsp_result_bus_dev_fn = res_ff.result_bus_dev_fn;

endmodule
`default_nettype wire

FILE: sim/pci_config_device_search_core_tb.sv
// Self-checking testbench for the PCI config device search core: planned walks, scoreboard.
module pci_config_device_search_core_tb;
   import pcids_pkg::*;

   typedef struct packed {
      phase_type   ph;
      logic [15:0] pos;
      logic [7:0]  last_bus;
      logic [7:0]  hdr;
      logic        multi;
      logic [15:0] left;
      logic [31:0] target;
      logic        by_class;
      logic        short_cls;
   } walk_state_type;

   typedef struct packed {
      logic     hold;
      item_type w;
   } req_entry_type;

   localparam int IDLE_PCT     = 19;
   localparam int RANDOM_WORDS = 900;
   localparam int MAX_SHOWN    = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       rsp_ready = 1'b0;
   item_type   drv = '0;
   wire        req_ready;
   wire        rsp_valid;
   wire [1:0]  rsp_status;
   wire [15:0] rsp_req_bus_dev_fn;
   wire [7:0]  rsp_req_offset;
   wire [15:0] rsp_result_bus_dev_fn;

   req_entry_type  req_words[$];
   result_type     rsp_due[$];
   walk_state_type plan_walk = '0;
   walk_state_type track_walk = '0;
   walk_state_type track_next;
   result_type     plan_last;
   result_type     due, got, want;
   req_entry_type  head;
   int             counted = 0;
   int             errors = 0;
   int             cyc = 0;
   logic           quiet;

   pci_config_device_search_core u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (drv.kind),
      .req_search_value      (drv.search_value),
      .req_occurrence        (drv.occurrence),
      .req_by_class          (drv.by_class),
      .req_skip_prog_if      (drv.skip_prog_if),
      .req_read_data         (drv.read_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_req_bus_dev_fn    (rsp_req_bus_dev_fn),
      .rsp_req_offset        (rsp_req_offset),
      .rsp_result_bus_dev_fn (rsp_result_bus_dev_fn)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next search state and answer word for one input word
   function automatic result_type search_step(input walk_state_type cur, input item_type w,
                                              output walk_state_type nxt);
      walk_state_type s;
      result_type  r;
      logic [16:0] npos;
      logic [16:0] stride;
      logic [31:0] cmp;
      logic [7:0]  ofs;
      logic        adv, do_probe, do_after, emit;
      s        = cur;
      r.status = ST_IGNORED;
      r.req_bus_dev_fn    = 16'h0;
      r.req_offset        = 8'h0;
      r.result_bus_dev_fn = NO_LOCATION;
      adv      = 1'b0;
      do_probe = 1'b0;
      do_after = 1'b0;
      emit     = 1'b0;
      stride   = 17'd8;
      ofs      = OFS_ID;
      if (w.kind == KIND_START) begin
         s.target    = w.search_value;
         s.left      = w.occurrence;
         s.by_class  = w.by_class;
         s.short_cls = w.skip_prog_if;
         s.pos       = 16'h0;
         s.last_bus  = 8'h0;
         do_probe    = 1'b1;
      end else begin
         case (s.ph)
            PH_HDR: begin
               if (w.read_data[23:16] == HDR_ABSENT) begin
                  adv = 1'b1;
               end else begin
                  s.hdr    = w.read_data[23:16];
                  s.multi  = w.read_data[23];
                  do_after = 1'b1;
               end
            end
            PH_SUB: begin
               if (w.read_data[23:16] > s.last_bus) s.last_bus = w.read_data[23:16];
               s.ph = PH_DATA;
               ofs  = s.by_class ? OFS_CLASS : OFS_ID;
               emit = 1'b1;
            end
            PH_DATA: begin
               cmp = w.read_data;
               if (s.by_class) cmp = s.short_cls ? (w.read_data >> 16) : (w.read_data >> 8);
               if (cmp == s.target && s.left == 16'h0) begin
                  s.ph = PH_IDLE;
                  r.status = ST_FOUND;
                  r.result_bus_dev_fn = s.pos;
               end else begin
                  if (cmp == s.target) s.left = s.left - 16'd1;
                  adv    = 1'b1;
                  stride = s.multi ? 17'd1 : 17'd8;
               end
            end
            default: begin
            end
         endcase
      end
      if (adv) begin
         npos = {1'b0, s.pos} + stride;
         if (npos >= POS_LIMIT || npos[16:8] > {1'b0, s.last_bus}) begin
            s.ph = PH_IDLE;
            r.status = ST_NOTFOUND;
         end else begin
            s.pos    = npos[15:0];
            do_probe = 1'b1;
         end
      end
      if (do_probe) begin
         if (s.pos[2:0] == 3'd0) begin
            s.ph = PH_HDR;
            ofs  = OFS_HEADER;
            emit = 1'b1;
         end else begin
            do_after = 1'b1;
         end
      end
      if (do_after) begin
         if (s.hdr[2:0] == HDR_BRIDGE && s.pos[15:8] == 8'h0) begin
            s.ph = PH_SUB;
            ofs  = OFS_BRIDGE;
         end else begin
            s.ph = PH_DATA;
            ofs  = s.by_class ? OFS_CLASS : OFS_ID;
         end
         emit = 1'b1;
      end
      if (emit) begin
         r.status            = ST_REQ;
         r.req_bus_dev_fn    = s.pos;
         r.req_offset        = ofs;
         r.result_bus_dev_fn = NO_LOCATION;
      end
      nxt = s;
      return r;
   endfunction

   function automatic int pct();
      return $urandom_range(0, 99);
   endfunction

   function automatic item_type rand_word(input logic kind);
      item_type w;
      w.kind         = kind;
      w.search_value = $urandom;
      w.occurrence   = 16'($urandom);
      w.by_class     = 1'($urandom);
      w.skip_prog_if = 1'($urandom);
      w.read_data    = $urandom;
      return w;
   endfunction

   task automatic add_word(input item_type w, input logic hold);
      walk_state_type nxt;
      req_entry_type  e;
      plan_last = search_step(plan_walk, w, nxt);
      plan_walk = nxt;
      if (plan_last.status != ST_IGNORED) counted++;
      e.hold = hold;
      e.w    = w;
      req_words.push_back(e);
   endtask

   task automatic feed(input logic [31:0] rd);
      item_type w;
      w = rand_word(1'b1);
      w.read_data = rd;
      add_word(w, 1'b0);
   endtask

   task automatic begin_search(input logic [31:0] tgt, input logic [15:0] occ,
                               input logic cls, input logic short_cls, input logic hold);
      item_type w;
      w = rand_word(KIND_START);
      w.search_value = tgt;
      w.occurrence   = occ;
      w.by_class     = cls;
      w.skip_prog_if = short_cls;
      add_word(w, hold);
   endtask

   // plausible config dword for the last planned read request
   task automatic answer(input int p_absent, input int p_mf, input int p_bridge,
                         input int p_match);
      logic [31:0] d;
      logic [7:0]  hb;
      d = $urandom;
      case (plan_last.req_offset)
         OFS_HEADER: begin
            if (pct() < p_absent) begin
               d[23:16] = HDR_ABSENT;
            end else begin
               hb = 8'($urandom);
               hb[7] = pct() < p_mf;
               if (pct() < p_bridge) hb[2:0] = HDR_BRIDGE;
               else if (hb[2:0] == HDR_BRIDGE) hb[2:0] = 3'd0;
               if (hb == HDR_ABSENT) hb[6] = 1'b0;
               d[23:16] = hb;
            end
         end
         OFS_BRIDGE: d[23:16] = 8'($urandom_range(0, 3));
         default: begin
            if (pct() < p_match) begin
               if (!plan_walk.by_class) d = plan_walk.target;
               else if (plan_walk.short_cls) d[31:16] = plan_walk.target[15:0];
               else d[31:8] = plan_walk.target[23:0];
            end
         end
      endcase
      feed(d);
   endtask

   always @(posedge clock) begin
      cyc <= cyc + 1;
   end

   assign quiet = (cyc >= 300 && cyc < 700);

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            due = search_step(track_walk, drv, track_next);
            track_walk = track_next;
            rsp_due.push_back(due);
         end
         if (!req_valid || req_ready) begin
            if (req_words.size() == 0 || (req_words[0].hold && rsp_due.size() != 0)
                || (!quiet && pct() < IDLE_PCT)) begin
               req_valid <= 1'b0;
            end else begin
               head = req_words.pop_front();
               drv <= head.w;
               req_valid <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_req_bus_dev_fn, rsp_req_offset, rsp_result_bus_dev_fn};
            if (rsp_due.size() == 0) begin
               errors++;
               if (errors <= MAX_SHOWN)
                  $display("unexpected word: status %0d bdf %h ofs %h loc %h",
                           got.status, got.req_bus_dev_fn, got.req_offset,
                           got.result_bus_dev_fn);
            end else begin
               want = rsp_due.pop_front();
               if (got.status !== want.status || got.req_bus_dev_fn !== want.req_bus_dev_fn
                   || got.req_offset !== want.req_offset
                   || got.result_bus_dev_fn !== want.result_bus_dev_fn) begin
                  errors++;
                  if (errors <= MAX_SHOWN)
                     $display("mismatch: exp status %0d bdf %h ofs %h loc %h, got %0d %h %h %h",
                              want.status, want.req_bus_dev_fn, want.req_offset,
                              want.result_bus_dev_fn, got.status, got.req_bus_dev_fn,
                              got.req_offset, got.result_bus_dev_fn);
               end
            end
         end
         rsp_ready <= quiet ? 1'b1 : (pct() >= IDLE_PCT);
      end
   end

   initial begin
      item_type    w;
      logic [31:0] tgt;
      logic [15:0] occ;
      logic        cls, sc;
      int          p_absent, p_mf, p_bridge, p_match, steps, nsearch, r;

      // returned dwords with no search running
      w = '1;
      add_word(w, 1'b0);
      w = '0;
      w.kind = 1'b1;
      add_word(w, 1'b0);

      // ID match at the very first slot
      begin_search(32'hFFFF_FFFF, 16'h0, 1'b0, 1'b0, 1'b0);
      feed(32'h0000_0000);
      feed(32'hFFFF_FFFF);

      // 24-bit class, empty slot, multi-function device, second hit wins
      begin_search(32'h00FF_FFFF, 16'h1, 1'b1, 1'b0, 1'b0);
      feed(32'h00FF_0000);
      feed(32'h0080_0000);
      feed(32'hFFFF_FF5A);
      feed(32'hFFFF_FFA5);

      // 16-bit class, bridge on bus 0, then aborted by a new start
      begin_search(32'h0000_ABCD, 16'h0, 1'b1, 1'b1, 1'b0);
      feed(32'h0001_0000);
      feed(32'h0002_0000);
      feed(32'h1234_0000);
      begin_search(32'h0000_0000, 16'hFFFF, 1'b0, 1'b1, 1'b0);
      feed(32'hFFFF_FFFF);
      feed(32'h0000_0000);
      feed(32'h0000_0000);
      begin_search(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
      feed(32'h0000_0000);
      feed(32'hFFFF_FFFF);

      counted = 0;
      nsearch = 0;
      while (counted < RANDOM_WORDS) begin
         cls = 1'($urandom);
         sc  = 1'($urandom);
         tgt = $urandom;
         if (cls && pct() < 85) tgt = sc ? (tgt & 32'h0000_FFFF) : (tgt & 32'h00FF_FFFF);
         case ($urandom_range(0, 9))
            0: occ = 16'($urandom);
            1: occ = 16'hFFFF;
            default: occ = 16'($urandom_range(0, 3));
         endcase
         begin_search(tgt, occ, cls, sc, (nsearch % 6) == 0);
         p_absent = $urandom_range(10, 70);
         p_mf     = $urandom_range(0, 50);
         p_bridge = $urandom_range(0, 15);
         p_match  = $urandom_range(5, 40);
         steps    = 0;
         while (plan_walk.ph != PH_IDLE && steps < 400) begin
            r = pct();
            if (r < 2) steps = 400;
            else if (r < 5) add_word(rand_word(1'b1), 1'b0);
            else answer(p_absent, p_mf, p_bridge, p_match);
            steps++;
         end
         if (pct() < 30) add_word(rand_word(1'b1), 1'b0);
         nsearch++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (req_words.size() != 0 || req_valid || rsp_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
src/pcids_pkg.sv
src/pcids_step.sv
src/pci_config_device_search_core.sv
sim/pci_config_device_search_core_tb.sv
